>>> src/camera_basis_from_gaze_unit_macros.svh
// Assertion macros for the camera basis unit.
// Used by camera_basis_from_gaze_unit.sv; expects clk and rst_n in scope.
`ifndef CAMERA_BASIS_FROM_GAZE_UNIT_MACROS_SVH
`define CAMERA_BASIS_FROM_GAZE_UNIT_MACROS_SVH

// ante implies cons in the same cycle
`define CBG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cond never holds
`define CBG_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> src/cbg_pkg.sv
// Shared types and constants for the camera basis unit.
// No dependencies; used by cbg_unit_vec and camera_basis_from_gaze_unit.
package cbg_pkg;

  localparam int IN_W      = 16;
  localparam int FRAC_BITS = 14;
  localparam int OUT_W     = FRAC_BITS + 2;
  localparam int NORM_W    = 31;   // normalized magnitude, top in [2^30, 2^31)
  localparam int ROOT_W    = 32;
  localparam int SUM_W     = 64;
  // normalizer depth: lzc, shift, square, sum, 32 root steps, prep,
  // FRAC_BITS+1 divide steps, sign
  localparam int UV_STAGES = FRAC_BITS + 39;

  typedef struct packed {
    logic signed [IN_W-1:0] gaze_x;
    logic signed [IN_W-1:0] gaze_y;
    logic signed [IN_W-1:0] gaze_z;
    logic signed [IN_W-1:0] world_up_x;
    logic signed [IN_W-1:0] world_up_y;
    logic signed [IN_W-1:0] world_up_z;
  } cbg_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] fwd_x;
    logic signed [OUT_W-1:0] fwd_y;
    logic signed [OUT_W-1:0] fwd_z;
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] right_y;
    logic signed [OUT_W-1:0] right_z;
    logic signed [OUT_W-1:0] cam_up_x;
    logic signed [OUT_W-1:0] cam_up_y;
    logic signed [OUT_W-1:0] cam_up_z;
    logic                    degenerate;
  } cbg_out_t;

endpackage

>>> src/camera_basis_from_gaze_unit.sv
// Look-at camera basis: top level with the two normalizers and the cross products.
// Depends on cbg_pkg, cbg_unit_vec and camera_basis_from_gaze_unit_macros.svh.
//
// Usage:
//  - Input: drive in_data (gaze and world up triples) and pulse start. A
//    transaction is taken at each rising edge with start high and busy low.
//    busy is low whenever reset is released, so one transaction per cycle,
//    back to back, is always accepted.
//  - Output: out_valid is high for exactly one cycle with the basis on
//    out_data. forward = -gaze/|gaze|, right = up x forward normalized,
//    cam_up = forward x right, all Q1.14. A zero gaze or an up vector whose
//    cross product with forward is exactly zero gives all-zero vectors and
//    degenerate = 1.
//  - Path: input register, forward normalizer, up x forward registers,
//    right normalizer, cam_up registers and output register. Throughput
//    one transaction per clock. Depth comes from the two normalizers, 53
//    stages each: a 32-step root and a 15-step divide, one bit per stage.
//  - Reset (rst_n low, synchronous) flushes every in-flight transaction.
//  - The receiver cannot stall; results are never held.
`include "camera_basis_from_gaze_unit_macros.svh"

module camera_basis_from_gaze_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cbg_pkg::cbg_in_t  in_data,
  output logic              out_valid,
  output cbg_pkg::cbg_out_t out_data
);

  localparam int W   = cbg_pkg::IN_W;
  localparam int FB  = cbg_pkg::FRAC_BITS;
  localparam int OW  = cbg_pkg::OUT_W;
  localparam int PW  = W + OW;        // up * forward product
  localparam int CW  = PW + 1;        // up x forward component
  localparam int M2W = W + FB + 1;    // |up x forward|
  localparam int QW  = 2 * OW;        // forward * right product
  localparam int TW  = QW + 1;        // forward x right component
  localparam int ONE = 1 << FB;
  localparam int LAT = 2 * cbg_pkg::UV_STAGES + 8;

  // ---------------- input register
  logic                  in_vld_r;
  logic signed [W-1:0]   g_r  [3];
  logic signed [W-1:0]   up_r [3];
  logic [2:0][W-1:0]     g_mag;
  logic [2:0]            g_neg;
  logic                  acc_zero;

  assign busy     = !rst_n;
  assign acc_zero = start && !busy && in_data.gaze_x == '0 && in_data.gaze_y == '0 &&
                    in_data.gaze_z == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    g_r[0]  <= in_data.gaze_x;
    g_r[1]  <= in_data.gaze_y;
    g_r[2]  <= in_data.gaze_z;
    up_r[0] <= in_data.world_up_x;
    up_r[1] <= in_data.world_up_y;
    up_r[2] <= in_data.world_up_z;
  end

  // forward is -gaze: negative where gaze is positive
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_mag[i] = g_r[i][W-1] ? W'(-g_r[i]) : W'(g_r[i]);
      g_neg[i] = !g_r[i][W-1];
    end
  end

  // ---------------- forward normalizer
  logic                  u1_vld, u1_ok;
  logic [2:0][OW-1:0]    u1_f;
  logic [3*W-1:0]        u1_side;

  cbg_unit_vec #(
    .MW     (W),
    .SIDE_W (3 * W)
  ) u_fwd (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld_r),
    .in_mag   (g_mag),
    .in_neg   (g_neg),
    .in_side  ({up_r[2], up_r[1], up_r[0]}),
    .out_vld  (u1_vld),
    .out_u    (u1_f),
    .out_ok   (u1_ok),
    .out_side (u1_side)
  );

  // ---------------- right = up x forward
  logic                  x1_vld_r, x2_vld_r, x3_vld_r;
  logic signed [PW-1:0]  x1_p_r [6];
  logic signed [CW-1:0]  x2_c_r [3];
  logic [2:0][M2W-1:0]   x3_mag_r;
  logic [2:0]            x3_neg_r;
  logic [2:0][OW-1:0]    x1_f_r, x2_f_r, x3_f_r;
  logic                  x1_ok_r, x2_ok_r, x3_ok_r;
  logic signed [W-1:0]   upv [3];
  logic signed [OW-1:0]  fv  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      upv[i] = $signed(u1_side[i*W +: W]);
      fv[i]  = $signed(u1_f[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r <= 1'b0;
      x2_vld_r <= 1'b0;
      x3_vld_r <= 1'b0;
    end else begin
      x1_vld_r <= u1_vld;
      x2_vld_r <= x1_vld_r;
      x3_vld_r <= x2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_p_r[0] <= PW'(upv[1]) * PW'(fv[2]);
    x1_p_r[1] <= PW'(upv[2]) * PW'(fv[1]);
    x1_p_r[2] <= PW'(upv[2]) * PW'(fv[0]);
    x1_p_r[3] <= PW'(upv[0]) * PW'(fv[2]);
    x1_p_r[4] <= PW'(upv[0]) * PW'(fv[1]);
    x1_p_r[5] <= PW'(upv[1]) * PW'(fv[0]);
    x1_f_r    <= u1_f;
    x1_ok_r   <= u1_ok;
    for (int i = 0; i < 3; i++) begin
      x2_c_r[i]   <= CW'(x1_p_r[2*i]) - CW'(x1_p_r[2*i+1]);
      x3_mag_r[i] <= x2_c_r[i][CW-1] ? M2W'(-x2_c_r[i]) : M2W'(x2_c_r[i]);
      x3_neg_r[i] <= x2_c_r[i][CW-1];
    end
    x2_f_r  <= x1_f_r;
    x2_ok_r <= x1_ok_r;
    x3_f_r  <= x2_f_r;
    x3_ok_r <= x2_ok_r;
  end

  // ---------------- right normalizer
  logic                  u2_vld, u2_ok;
  logic [2:0][OW-1:0]    u2_r;
  logic [3*OW:0]         u2_side;

  cbg_unit_vec #(
    .MW     (M2W),
    .SIDE_W (3 * OW + 1)
  ) u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (x3_vld_r),
    .in_mag   (x3_mag_r),
    .in_neg   (x3_neg_r),
    .in_side  ({x3_ok_r, x3_f_r}),
    .out_vld  (u2_vld),
    .out_u    (u2_r),
    .out_ok   (u2_ok),
    .out_side (u2_side)
  );

  // ---------------- cam_up = forward x right, rounded half away from zero
  logic                  c1_vld_r, c2_vld_r, c3_vld_r, out_vld_r;
  logic signed [QW-1:0]  c1_p_r [6];
  logic signed [TW-1:0]  c2_t_r [3];
  logic [2:0][TW-1:0]    c3_mag_r;
  logic [2:0]            c3_neg_r;
  logic [2:0][OW-1:0]    c1_f_r, c2_f_r, c3_f_r, c1_r_r, c2_r_r, c3_r_r;
  logic                  c1_ok_r, c2_ok_r, c3_ok_r;
  logic signed [OW-1:0]  f2v [3];
  logic signed [OW-1:0]  r2v [3];
  logic [2:0][OW-1:0]    cu;
  cbg_pkg::cbg_out_t     out_nxt, out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f2v[i] = $signed(u2_side[i*OW +: OW]);
      r2v[i] = $signed(u2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r  <= 1'b0;
      c2_vld_r  <= 1'b0;
      c3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      c1_vld_r  <= u2_vld;
      c2_vld_r  <= c1_vld_r;
      c3_vld_r  <= c2_vld_r;
      out_vld_r <= c3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_p_r[0] <= QW'(f2v[1]) * QW'(r2v[2]);
    c1_p_r[1] <= QW'(f2v[2]) * QW'(r2v[1]);
    c1_p_r[2] <= QW'(f2v[2]) * QW'(r2v[0]);
    c1_p_r[3] <= QW'(f2v[0]) * QW'(r2v[2]);
    c1_p_r[4] <= QW'(f2v[0]) * QW'(r2v[1]);
    c1_p_r[5] <= QW'(f2v[1]) * QW'(r2v[0]);
    c1_f_r    <= u2_side[3*OW-1:0];
    c1_r_r    <= u2_r;
    c1_ok_r   <= u2_ok && u2_side[3*OW];
    for (int i = 0; i < 3; i++) begin
      c2_t_r[i]   <= TW'(c1_p_r[2*i]) - TW'(c1_p_r[2*i+1]);
      c3_mag_r[i] <= c2_t_r[i][TW-1] ? TW'(-c2_t_r[i]) : TW'(c2_t_r[i]);
      c3_neg_r[i] <= c2_t_r[i][TW-1];
    end
    c2_f_r  <= c1_f_r;
    c2_r_r  <= c1_r_r;
    c2_ok_r <= c1_ok_r;
    c3_f_r  <= c2_f_r;
    c3_r_r  <= c2_r_r;
    c3_ok_r <= c2_ok_r;
    out_r   <= out_nxt;
  end

  always_comb begin
    logic [TW:0]   rnd;
    logic [OW-1:0] q;
    for (int i = 0; i < 3; i++) begin
      rnd = ((TW+1)'(c3_mag_r[i]) + (TW+1)'(ONE / 2)) >> FB;
      q   = (rnd > (TW+1)'(ONE)) ? OW'(ONE) : OW'(rnd);
      cu[i] = c3_neg_r[i] ? -q : q;
    end
    if (c3_ok_r) begin
      out_nxt.fwd_x      = $signed(c3_f_r[0]);
      out_nxt.fwd_y      = $signed(c3_f_r[1]);
      out_nxt.fwd_z      = $signed(c3_f_r[2]);
      out_nxt.right_x    = $signed(c3_r_r[0]);
      out_nxt.right_y    = $signed(c3_r_r[1]);
      out_nxt.right_z    = $signed(c3_r_r[2]);
      out_nxt.cam_up_x   = $signed(cu[0]);
      out_nxt.cam_up_y   = $signed(cu[1]);
      out_nxt.cam_up_z   = $signed(cu[2]);
      out_nxt.degenerate = 1'b0;
    end else begin
      out_nxt            = '0;
      out_nxt.degenerate = 1'b1;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // ---------------- checks
  `CBG_ASSERT_IMPL(a_degen_zero, out_valid && out_data.degenerate, out_data.fwd_x == '0 && out_data.fwd_y == '0 && out_data.fwd_z == '0 && out_data.right_x == '0 && out_data.right_y == '0 && out_data.right_z == '0 && out_data.cam_up_x == '0 && out_data.cam_up_y == '0 && out_data.cam_up_z == '0, "degenerate result carries nonzero vectors")
  `CBG_ASSERT_IMPL(a_fwd_unit, out_valid && !out_data.degenerate, out_data.fwd_x != '0 || out_data.fwd_y != '0 || out_data.fwd_z != '0, "forward vector is zero")
  `CBG_ASSERT_IMPL(a_right_unit, out_valid && !out_data.degenerate, out_data.right_x != '0 || out_data.right_y != '0 || out_data.right_z != '0, "right vector is zero")
  `CBG_ASSERT_IMPL(a_zero_gaze, out_valid && $past(acc_zero, LAT), out_data.degenerate, "zero gaze not flagged")
  `CBG_ASSERT_NEVER(a_range, out_valid && (out_data.fwd_x > ONE || out_data.right_x > ONE || out_data.cam_up_x > ONE || out_data.cam_up_x < -ONE), "component out of unit range")

endmodule

>>> src/cbg_unit_vec.sv
// Pipelined 3-vector normalizer: magnitudes and signs in, Q1.FRAC unit vector out.
// Depends on cbg_pkg. Sideband travels alongside, aligned with the result.
module cbg_unit_vec #(
  parameter int MW     = 16,
  parameter int SIDE_W = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic [2:0][MW-1:0]                  in_mag,
  input  logic [2:0]                          in_neg,
  input  logic [SIDE_W-1:0]                   in_side,
  output logic                                out_vld,
  output logic [2:0][cbg_pkg::OUT_W-1:0]      out_u,
  output logic                                out_ok,
  output logic [SIDE_W-1:0]                   out_side
);

  localparam int FB       = cbg_pkg::FRAC_BITS;
  localparam int OW       = cbg_pkg::OUT_W;
  localparam int NW       = cbg_pkg::NORM_W;
  localparam int RW       = cbg_pkg::ROOT_W;
  localparam int SW       = cbg_pkg::SUM_W;
  localparam int REMW     = RW + 1;
  localparam int DW       = NW + FB + 1;
  localparam int PBW      = $clog2(MW);
  localparam int SHW      = $clog2(MW + 1);
  localparam int CBW      = SIDE_W + 4;
  localparam int SQ_FIRST = 4;
  localparam int SQ_LAST  = SQ_FIRST + RW - 1;
  localparam int DP       = SQ_LAST + 1;
  localparam int DV_LAST  = DP + FB + 1;
  localparam int NST      = cbg_pkg::UV_STAGES;

  logic                   vld_r [NST];
  logic [CBW-1:0]         cb_r  [NST];   // {side, neg[2:0], nonzero}

  logic [MW-1:0]          or_v;
  logic [PBW-1:0]         p_nxt, p_r;
  logic [2:0][MW-1:0]     mag0_r;
  logic [SHW-1:0]         sh;
  logic [2:0][NW-1:0]     m_nxt;
  logic [2:0][NW-1:0]     m_r [1:DP-1];
  logic [2:0][2*NW-1:0]   sq_nxt, sq_r;
  logic [SW-1:0]          s_nxt;
  logic [SW-1:0]          s_r [3:SQ_LAST];
  logic [REMW-1:0]        rem_nxt [SQ_FIRST:SQ_LAST];
  logic [REMW-1:0]        rem_r   [SQ_FIRST:SQ_LAST];
  logic [RW-1:0]          root_nxt [SQ_FIRST:SQ_LAST];
  logic [RW-1:0]          root_r   [SQ_FIRST:SQ_LAST];
  logic [2:0][RW-1:0]     r0_nxt;
  logic [2:0][FB:0]       dl0_nxt;
  logic [RW-1:0]          n_r  [DP:DV_LAST];
  logic [2:0][RW-1:0]     r_r  [DP:DV_LAST];
  logic [2:0][RW-1:0]     r_nxt [DP+1:DV_LAST];
  logic [2:0][FB:0]       dl_r [DP:DV_LAST];
  logic [2:0][FB:0]       q_r  [DP:DV_LAST];
  logic [2:0][FB:0]       q_nxt [DP+1:DV_LAST];
  logic [2:0][OW-1:0]     u_nxt, u_r;

  always_comb begin
    logic [MW+NW-1:0] wide;
    logic [REMW-1:0]  rem_p;
    logic [RW-1:0]    root_p;
    logic [REMW+1:0]  rsh, rtr;
    logic [DW-1:0]    d;
    logic [RW:0]      t;
    logic [OW-1:0]    uq;

    // msb position of the largest magnitude
    or_v  = in_mag[0] | in_mag[1] | in_mag[2];
    p_nxt = '0;
    for (int b = 0; b < MW; b++) begin
      if (or_v[b]) p_nxt = PBW'(b);
    end

    // scale so the largest lands in [2^30, 2^31), truncating on right shifts
    sh = SHW'(p_r) + SHW'(1);
    for (int i = 0; i < 3; i++) begin
      wide     = {mag0_r[i], {NW{1'b0}}} >> sh;
      m_nxt[i] = wide[NW-1:0];
    end

    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = (2*NW)'(m_r[1][i]) * (2*NW)'(m_r[1][i]);
    end
    s_nxt = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);

    // restoring square root, one result bit per stage
    for (int j = SQ_FIRST; j <= SQ_LAST; j++) begin
      if (j == SQ_FIRST) begin
        rem_p  = '0;
        root_p = '0;
      end else begin
        rem_p  = rem_r[j-1];
        root_p = root_r[j-1];
      end
      rsh = {rem_p, s_r[j-1][SW-1 -: 2]};
      rtr = (REMW+2)'({root_p, 2'b01});
      if (rsh >= rtr) begin
        rem_nxt[j]  = REMW'(rsh - rtr);
        root_nxt[j] = {root_p[RW-2:0], 1'b1};
      end else begin
        rem_nxt[j]  = rsh[REMW-1:0];
        root_nxt[j] = {root_p[RW-2:0], 1'b0};
      end
    end

    // dividend m*2^FB + n/2; quotient fits FB+1 bits since m <= n
    for (int i = 0; i < 3; i++) begin
      d = DW'({m_r[DP-1][i], {FB{1'b0}}}) + DW'(root_r[SQ_LAST] >> 1);
      r0_nxt[i]  = RW'(d >> (FB + 1));
      dl0_nxt[i] = d[FB:0];
    end

    for (int k = DP + 1; k <= DV_LAST; k++) begin
      for (int i = 0; i < 3; i++) begin
        t = {r_r[k-1][i], dl_r[k-1][i][FB]};
        if (t >= {1'b0, n_r[k-1]}) begin
          r_nxt[k][i] = RW'(t - {1'b0, n_r[k-1]});
          q_nxt[k][i] = {q_r[k-1][i][FB-1:0], 1'b1};
        end else begin
          r_nxt[k][i] = t[RW-1:0];
          q_nxt[k][i] = {q_r[k-1][i][FB-1:0], 1'b0};
        end
      end
    end

    for (int i = 0; i < 3; i++) begin
      uq = OW'(q_r[DV_LAST][i]);
      if (!cb_r[DV_LAST][0]) begin
        u_nxt[i] = '0;
      end else if (cb_r[DV_LAST][1+i]) begin
        u_nxt[i] = -uq;
      end else begin
        u_nxt[i] = uq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < NST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    cb_r[0] <= {in_side, in_neg, |or_v};
    for (int k = 1; k < NST; k++) cb_r[k] <= cb_r[k-1];
    mag0_r  <= in_mag;
    p_r     <= p_nxt;
    m_r[1]  <= m_nxt;
    for (int k = 2; k < DP; k++) m_r[k] <= m_r[k-1];
    sq_r    <= sq_nxt;
    s_r[3]  <= s_nxt;
    for (int j = SQ_FIRST; j <= SQ_LAST; j++) begin
      s_r[j]    <= s_r[j-1] << 2;
      rem_r[j]  <= rem_nxt[j];
      root_r[j] <= root_nxt[j];
    end
    n_r[DP]  <= root_r[SQ_LAST];
    r_r[DP]  <= r0_nxt;
    dl_r[DP] <= dl0_nxt;
    q_r[DP]  <= '0;
    for (int k = DP + 1; k <= DV_LAST; k++) begin
      n_r[k]  <= n_r[k-1];
      r_r[k]  <= r_nxt[k];
      dl_r[k] <= dl_r[k-1] << 1;
      q_r[k]  <= q_nxt[k];
    end
    u_r <= u_nxt;
  end

  assign out_vld  = vld_r[NST-1];
  assign out_u    = u_r;
  assign out_ok   = cb_r[NST-1][0];
  assign out_side = cb_r[NST-1][CBW-1 -: SIDE_W];

endmodule

>>> test/tb_camera_basis_from_gaze_unit.sv
// Testbench for camera_basis_from_gaze_unit: directed and random gaze/up pairs,
// each checked field by field against an in-bench fixed-point look-at predictor.
// Depends on cbg_pkg and the camera_basis_from_gaze_unit RTL.
module tb_camera_basis_from_gaze_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 113;
  localparam int CYCLE_CAP = 200000;
  localparam int IW        = cbg_pkg::IN_W;
  localparam int OW        = cbg_pkg::OUT_W;
  localparam int FB        = cbg_pkg::FRAC_BITS;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  cbg_pkg::cbg_in_t  in_data = '0;
  logic              out_valid;
  cbg_pkg::cbg_out_t out_data;

  int unsigned       fail_count = 0;
  int unsigned       cycle_count = 0;
  cbg_pkg::cbg_out_t basis_queue[$];

  always #10 clk = ~clk;

  camera_basis_from_gaze_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // Integer square root, floor.
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Scale a triple to unit length in Q1.FRAC_BITS; returns 0 on a zero vector.
  function automatic bit normalize3(input longint v[3], output longint u[3]);
    longint unsigned m[3], top, sum, len, q;
    for (int i = 0; i < 3; i++) m[i] = (v[i] < 0) ? -v[i] : v[i];
    top = m[0];
    if (m[1] > top) top = m[1];
    if (m[2] > top) top = m[2];
    if (top == 0) return 1'b0;
    while (top < (64'd1 << 30)) begin
      top <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    while (top >= (64'd1 << 31)) begin
      top >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (len >> 1)) / len;
      if (q > (64'd1 << FB)) q = 64'd1 << FB;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // Round to FRAC_BITS half away from zero, saturate to +-1.0.
  function automatic longint round_unit(input longint v);
    longint unsigned m, q;
    m = (v < 0) ? -v : v;
    q = (m + (64'd1 << (FB - 1))) >> FB;
    if (q > (64'd1 << FB)) q = 64'd1 << FB;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic cbg_pkg::cbg_out_t look_at_basis(input cbg_pkg::cbg_in_t tr);
    longint neg_gaze[3], up[3], fwd[3], side[3], rgt[3], cu[3];
    cbg_pkg::cbg_out_t res;
    bit ok;
    neg_gaze[0] = -longint'(tr.gaze_x);
    neg_gaze[1] = -longint'(tr.gaze_y);
    neg_gaze[2] = -longint'(tr.gaze_z);
    up[0] = longint'(tr.world_up_x);
    up[1] = longint'(tr.world_up_y);
    up[2] = longint'(tr.world_up_z);
    res = '0;
    ok = normalize3(neg_gaze, fwd);
    if (ok) begin
      cross3(up, fwd, side);
      ok = normalize3(side, rgt);
    end
    if (!ok) begin
      res.degenerate = 1'b1;
      return res;
    end
    cross3(fwd, rgt, cu);
    res.fwd_x = OW'(fwd[0]);   res.fwd_y = OW'(fwd[1]);   res.fwd_z = OW'(fwd[2]);
    res.right_x = OW'(rgt[0]); res.right_y = OW'(rgt[1]); res.right_z = OW'(rgt[2]);
    res.cam_up_x = OW'(round_unit(cu[0]));
    res.cam_up_y = OW'(round_unit(cu[1]));
    res.cam_up_z = OW'(round_unit(cu[2]));
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    fail_count++;
    $display("ERROR t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Burst/gap shaping of the sender.
  int burst_left = 0;

  // Send one transaction; start stays high across back-to-back sends.
  task automatic send_gaze(input cbg_pkg::cbg_in_t tr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_data <= tr;
    do @(posedge clk); while (busy);
    basis_queue.push_back(look_at_basis(tr));
  endtask

  task automatic send_vecs(input int gx, gy, gz, ux, uy, uz);
    cbg_pkg::cbg_in_t tr;
    tr.gaze_x = IW'(gx); tr.gaze_y = IW'(gy); tr.gaze_z = IW'(gz);
    tr.world_up_x = IW'(ux); tr.world_up_y = IW'(uy); tr.world_up_z = IW'(uz);
    send_gaze(tr);
  endtask

  // Result checker: results come one cycle wide and cannot be stalled.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (basis_queue.size() == 0) begin
        report_mismatch("unexpected transaction", longint'(0), longint'(0));
      end else begin
        cbg_pkg::cbg_out_t want;
        want = basis_queue.pop_front();
        if (out_data.fwd_x != want.fwd_x)
          report_mismatch("fwd_x", longint'(out_data.fwd_x), longint'(want.fwd_x));
        if (out_data.fwd_y != want.fwd_y)
          report_mismatch("fwd_y", longint'(out_data.fwd_y), longint'(want.fwd_y));
        if (out_data.fwd_z != want.fwd_z)
          report_mismatch("fwd_z", longint'(out_data.fwd_z), longint'(want.fwd_z));
        if (out_data.right_x != want.right_x)
          report_mismatch("right_x", longint'(out_data.right_x), longint'(want.right_x));
        if (out_data.right_y != want.right_y)
          report_mismatch("right_y", longint'(out_data.right_y), longint'(want.right_y));
        if (out_data.right_z != want.right_z)
          report_mismatch("right_z", longint'(out_data.right_z), longint'(want.right_z));
        if (out_data.cam_up_x != want.cam_up_x)
          report_mismatch("cam_up_x", longint'(out_data.cam_up_x), longint'(want.cam_up_x));
        if (out_data.cam_up_y != want.cam_up_y)
          report_mismatch("cam_up_y", longint'(out_data.cam_up_y), longint'(want.cam_up_y));
        if (out_data.cam_up_z != want.cam_up_z)
          report_mismatch("cam_up_z", longint'(out_data.cam_up_z), longint'(want.cam_up_z));
        if (out_data.degenerate != want.degenerate)
          report_mismatch("degenerate", longint'(out_data.degenerate),
                          longint'(want.degenerate));
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_CAP) begin
      $display("camera_basis_from_gaze_unit: mismatch");
      $finish;
    end
  end

  // Corners: axes, extremes, zero gaze, zero up, parallel and near-parallel up.
  task automatic test_directed();
    send_vecs(0, 0, -1, 0, 1, 0);
    send_vecs(0, 0, 32767, 0, 32767, 0);
    send_vecs(-32768, -32768, -32768, 32767, -32768, 0);
    send_vecs(32767, 32767, 32767, -32768, -32768, 32767);
    send_vecs(-32768, 0, 0, 0, 0, -32768);
    send_vecs(1, 0, 0, 0, 0, 1);
    send_vecs(0, 0, 0, 0, 1, 0);             // zero gaze
    send_vecs(0, 0, 0, 0, 0, 0);
    send_vecs(0, 0, 5, 0, 0, 0);             // zero up
    send_vecs(0, 0, 5, 0, 0, -9);            // up parallel to gaze
    send_vecs(3, 3, 3, 7, 7, 7);             // parallel on a diagonal
    send_vecs(0, 0, 1000, 1, 0, 1000);       // nearly parallel, not degenerate
    send_vecs(-1, -1, -1, 1, 0, 0);
    send_vecs(32767, 1, -32768, -1, 32767, 2);
    send_vecs(100, -200, 300, -32768, 32767, -32768);
    send_vecs(-21, 17, 4, 1, 1, 1);
  endtask

  // Mostly full-range random, with small magnitudes and parallel pairs mixed in.
  task automatic test_random(input int count);
    cbg_pkg::cbg_in_t tr;
    int k, sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 9);
      tr = {$urandom, $urandom, $urandom};
      if (sel == 0) begin
        tr.gaze_x = IW'($signed($urandom_range(0, 6)) - 3);
        tr.gaze_y = IW'($signed($urandom_range(0, 6)) - 3);
        tr.gaze_z = IW'($signed($urandom_range(0, 6)) - 3);
      end else if (sel == 1) begin
        k = $signed($urandom_range(0, 20)) - 10;
        tr.gaze_x = IW'($signed($urandom_range(0, 400)) - 200);
        tr.gaze_y = IW'($signed($urandom_range(0, 400)) - 200);
        tr.gaze_z = IW'($signed($urandom_range(0, 400)) - 200);
        tr.world_up_x = IW'(tr.gaze_x * k);
        tr.world_up_y = IW'(tr.gaze_y * k);
        tr.world_up_z = IW'(tr.gaze_z * k);
      end else if (sel == 2) begin
        tr.world_up_x = IW'(tr.gaze_x + $signed($urandom_range(0, 2)) - 1);
        tr.world_up_y = tr.gaze_y;
        tr.world_up_z = tr.gaze_z;
      end
      send_gaze(tr);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1800);
    start <= 1'b0;
    while (basis_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("camera_basis_from_gaze_unit: match");
    end else begin
      $display("camera_basis_from_gaze_unit: mismatch");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+src
src/cbg_pkg.sv
src/cbg_unit_vec.sv
src/camera_basis_from_gaze_unit.sv
test/tb_camera_basis_from_gaze_unit.sv
